// File: hdl/lifo_stack_duplicate_detect_core_defines.svh
// Assertion macros shared by the block's checker.
// Each macro expects clk and arst_n in scope.
`ifndef LIFO_STACK_DUPLICATE_DETECT_CORE_DEFINES_SVH
`define LIFO_STACK_DUPLICATE_DETECT_CORE_DEFINES_SVH

// ante true -> cons true in the same cycle
`define LDD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// ante true -> cons true in the next cycle
`define LDD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// File: hdl/ldd_pkg.sv
// Shared types and constants for the LIFO stack with duplicate detect.
// No dependencies.
`default_nettype none
package ldd_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int WORD_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ENTRY_W     = 5;
	localparam int CMD_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// shift controls broadcast to every cell
	typedef struct packed {
		logic push_en;
		logic pop_en;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: hdl/ldd_cell.sv
// One stack slot: holds a word and its matches-below bit, shifts with its neighbors.
// Depends on ldd_pkg.
`default_nettype none
module ldd_cell (
	input  wire logic                            clk,
	input  wire ldd_pkg::cell_ctl_t              ctl,
	input  wire logic                            live,
	input  wire logic signed [ldd_pkg::WORD_W-1:0] probe,
	input  wire logic signed [ldd_pkg::WORD_W-1:0] up_value,
	input  wire logic                            up_match,
	input  wire logic signed [ldd_pkg::WORD_W-1:0] dn_value,
	input  wire logic                            dn_match,
	output logic signed [ldd_pkg::WORD_W-1:0]      value,
	output logic                                 match,
	output logic                                 hit
);

	logic signed [ldd_pkg::WORD_W-1:0] value_q;
	logic                              match_q;

	// push moves entries away from the top, pop moves them toward it
	always_ff @(posedge clk) begin
		if (ctl.push_en) begin
			value_q <= up_value;
			match_q <= up_match;
		end else if (ctl.pop_en) begin
			value_q <= dn_value;
			match_q <= dn_match;
		end
	end

	assign value = value_q;
	assign match = match_q;
	assign hit   = live && (value_q == probe);

endmodule
`default_nettype wire

// File: hdl/lifo_stack_duplicate_detect_core.sv
// Result is registered: valid on the master side in the cycle after request acceptance.
// Throughput: one request per cycle while results are taken; the single output register
// stalls the slave side only when a result is held and not taken.
// Cycle time is set by the parallel compare of the pushed word across all cells.
// Reset clears the entry count, duplicate count and output valid; stored words are not cleared.
`default_nettype none
module lifo_stack_duplicate_detect_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] push_value
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [31:0] top_value, [36:32] entry_count, [37] is_empty, [38] is_full,
	// [39] has_duplicate, [40] push_rejected
	output logic [47:0]      m_axis_tdata
);

	localparam int D = ldd_pkg::STACK_DEPTH;
	localparam int W = ldd_pkg::WORD_W;
	localparam int C = ldd_pkg::CNT_W;

	logic            accept;
	ldd_pkg::cmd_t   cmd;
	logic signed [W-1:0] push_value;

	logic [C-1:0] count_q, count_d;
	logic [C-1:0] dup_q, dup_d;
	logic         full, empty;
	logic         do_push, do_pop, do_clear, rejected;
	logic         hit_any;
	logic signed [W-1:0] top_d;
	ldd_pkg::cell_ctl_t ctl;

	logic signed [W-1:0] cell_value [D];
	logic                cell_match [D];
	logic [D-1:0]        cell_hit;

	logic                out_valid_q;
	logic signed [W-1:0] top_value_q;
	logic [ldd_pkg::ENTRY_W-1:0] entry_count_q;
	logic                is_empty_q, is_full_q, has_dup_q, rejected_q;

	assign cmd        = ldd_pkg::cmd_t'(s_axis_tuser);
	assign push_value = s_axis_tdata[W-1:0];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept     = s_axis_tvalid && s_axis_tready;

	assign full    = (count_q == C'(D));
	assign empty   = (count_q == '0);
	assign hit_any = |cell_hit;

	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_clear = 1'b0;
		rejected = 1'b0;
		if (accept) begin
			case (cmd)
				ldd_pkg::CMD_PUSH: begin
					if (full) rejected = 1'b1;
					else      do_push  = 1'b1;
				end
				ldd_pkg::CMD_POP:   do_pop   = !empty;
				ldd_pkg::CMD_CLEAR: do_clear = 1'b1;
				default: ;
			endcase
		end
	end

	assign ctl.push_en = do_push;
	assign ctl.pop_en  = do_pop;

	// dup count tracks live entries whose matches-below bit is set
	always_comb begin
		count_d = count_q;
		dup_d   = dup_q;
		if (do_push) begin
			count_d = count_q + C'(1);
			dup_d   = dup_q + C'(hit_any);
		end else if (do_pop) begin
			count_d = count_q - C'(1);
			dup_d   = dup_q - C'(cell_match[0]);
		end else if (do_clear) begin
			count_d = '0;
			dup_d   = '0;
		end
	end

	always_comb begin
		if (do_push)              top_d = push_value;
		else if (count_d == '0)   top_d = '0;
		else if (do_pop)          top_d = cell_value[1];
		else                      top_d = cell_value[0];
	end

	genvar i;
	generate
		for (i = 0; i < D; i++) begin : g_cell
			logic signed [W-1:0] up_v, dn_v;
			logic                up_m, dn_m;
			if (i == 0) begin : g_top
				assign up_v = push_value;
				assign up_m = hit_any;
			end else begin : g_mid
				assign up_v = cell_value[i-1];
				assign up_m = cell_match[i-1];
			end
			if (i == D - 1) begin : g_bot
				assign dn_v = '0;
				assign dn_m = 1'b0;
			end else begin : g_low
				assign dn_v = cell_value[i+1];
				assign dn_m = cell_match[i+1];
			end
			ldd_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.live     (C'(i) < count_q),
				.probe    (push_value),
				.up_value (up_v),
				.up_match (up_m),
				.dn_value (dn_v),
				.dn_match (dn_m),
				.value    (cell_value[i]),
				.match    (cell_match[i]),
				.hit      (cell_hit[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dup_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			dup_q   <= dup_d;
			if (accept)             out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_value_q   <= top_d;
			entry_count_q <= ldd_pkg::ENTRY_W'(count_d);
			is_empty_q    <= (count_d == '0);
			is_full_q     <= (count_d == C'(D));
			has_dup_q     <= (dup_d != '0);
			rejected_q    <= rejected;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, rejected_q, has_dup_q, is_full_q, is_empty_q,
		entry_count_q, top_value_q};

endmodule
`default_nettype wire

// File: hdl/ldd_checker.sv
// Port-level checks for the LIFO stack with duplicate detect; bound to the top level.
// Depends on lifo_stack_duplicate_detect_core_defines.svh.
`default_nettype none
`include "lifo_stack_duplicate_detect_core_defines.svh"
module ldd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic [1:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);

	logic in_fire;
	logic any_in_bits;
	assign in_fire     = s_axis_tvalid && s_axis_tready;
	assign any_in_bits = ^{s_axis_tdata, s_axis_tuser} || 1'b1;

	`LDD_ASSERT_IMP(a_ready_when_idle, !m_axis_tvalid, s_axis_tready)
	`LDD_ASSERT_NEXT(a_result_follows, in_fire && any_in_bits, m_axis_tvalid)
	`LDD_ASSERT_IMP(a_empty_matches_count, m_axis_tvalid,
		m_axis_tdata[37] == (m_axis_tdata[36:32] == 5'd0))
	`LDD_ASSERT_IMP(a_empty_is_clean, m_axis_tvalid && m_axis_tdata[37],
		m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[39] && !m_axis_tdata[40])
	`LDD_ASSERT_IMP(a_reject_only_full, m_axis_tvalid && m_axis_tdata[40], m_axis_tdata[38])

endmodule

bind lifo_stack_duplicate_detect_core ldd_checker u_ldd_checker (.*);
`default_nettype wire

// File: bench/tb_lifo_stack_duplicate_detect_core.sv
// Self-checking bench for lifo_stack_duplicate_detect_core: push, pop, clear and
// unused-code requests with random stalls on both stream sides.
// Depends on ldd_pkg for the command codes and sizes.
`default_nettype none
module tb_lifo_stack_duplicate_detect_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ldd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 80;

	typedef struct packed {
		logic                              push_rejected;
		logic                              has_duplicate;
		logic                              is_full;
		logic                              is_empty;
		logic [4:0]                        entry_count;
		logic signed [ldd_pkg::WORD_W-1:0] top_value;
	} stack_status_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] push_value
	logic [1:0]  s_axis_tuser;   // [1:0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [31:0] top_value, [36:32] entry_count, [37] is_empty, [38] is_full,
	// [39] has_duplicate, [40] push_rejected
	logic [47:0] m_axis_tdata;

	// shadow copy of the stack
	logic [ldd_pkg::WORD_W-1:0] shadow_words [ldd_pkg::STACK_DEPTH];
	logic                       shadow_dup   [ldd_pkg::STACK_DEPTH];
	int                         shadow_count;

	stack_status_t expected_status_q[$];
	stack_status_t want_status;
	stack_status_t got_status;

	int fail_count;
	int tx_gap_max;
	int rx_gap_max;
	int rx_hold_len;
	int idle_cycles;

	lifo_stack_duplicate_detect_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic stack_status_t apply_request(input logic [ldd_pkg::CMD_W-1:0] cmd,
			input logic [ldd_pkg::WORD_W-1:0] word);
		stack_status_t st;
		logic          hit;
		st  = '0;
		hit = 1'b0;
		if (cmd == ldd_pkg::CMD_PUSH) begin
			if (shadow_count >= ldd_pkg::STACK_DEPTH) begin
				st.push_rejected = 1'b1;
			end else begin
				for (int i = 0; i < shadow_count; i++)
					if (shadow_words[i] == word)
						hit = 1'b1;
				shadow_words[shadow_count] = word;
				shadow_dup[shadow_count]   = hit;
				shadow_count++;
			end
		end else if (cmd == ldd_pkg::CMD_POP) begin
			if (shadow_count > 0)
				shadow_count--;
		end else if (cmd == ldd_pkg::CMD_CLEAR) begin
			shadow_count = 0;
		end
		st.top_value   = (shadow_count > 0) ? shadow_words[shadow_count-1] : '0;
		st.entry_count = shadow_count[4:0];
		st.is_empty    = (shadow_count == 0);
		st.is_full     = (shadow_count == ldd_pkg::STACK_DEPTH);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_dup[i])
				st.has_duplicate = 1'b1;
		return st;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic send_request(input logic [ldd_pkg::CMD_W-1:0] cmd,
			input logic [ldd_pkg::WORD_W-1:0] word);
		int gap;
		gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_status_q.push_back(apply_request(cmd, word));
	endtask

	// drop valid and wait until every outstanding result has been taken
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_status_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_and_extremes();
		tx_gap_max = 9;
		rx_gap_max = 9;
		send_request(ldd_pkg::CMD_POP, 32'h0);
		send_request(CMD_UNUSED, 32'hFFFF_FFFF);
		send_request(ldd_pkg::CMD_PUSH, 32'h8000_0000);
		send_request(ldd_pkg::CMD_PUSH, 32'h7FFF_FFFF);
		send_request(ldd_pkg::CMD_PUSH, 32'h7FFF_FFFF);
		send_request(ldd_pkg::CMD_CLEAR, 32'h1234_5678);
		send_request(ldd_pkg::CMD_POP, 32'h0);
		// stale word below the cleared count must not count as a duplicate
		send_request(ldd_pkg::CMD_PUSH, 32'h8000_0000);
		send_request(ldd_pkg::CMD_PUSH, 32'hFFFF_FFFF);
		send_request(ldd_pkg::CMD_POP, 32'h5A5A_5A5A);
	endtask

	task automatic test_fill_and_overflow();
		tx_gap_max = 0;
		rx_gap_max = 0;
		send_request(ldd_pkg::CMD_CLEAR, 32'h0);
		for (int i = 0; i < ldd_pkg::STACK_DEPTH; i++)
			send_request(ldd_pkg::CMD_PUSH, (i == 9) ? 32'h0000_0003 : 32'(i));
		send_request(ldd_pkg::CMD_PUSH, 32'hDEAD_BEEF);
		send_request(CMD_UNUSED, 32'h0);
		send_request(ldd_pkg::CMD_POP, 32'h0);
	endtask

	task automatic test_output_backpressure();
		tx_gap_max  = 0;
		rx_gap_max  = 0;
		rx_hold_len = LONG_HOLD;
		for (int i = 0; i < 12; i++)
			send_request((i % 3 == 2) ? ldd_pkg::CMD_POP : ldd_pkg::CMD_PUSH, $urandom);
	endtask

	task automatic test_drain_between_bursts();
		tx_gap_max = 9;
		rx_gap_max = 9;
		for (int i = 0; i < 6; i++)
			send_request(ldd_pkg::CMD_PUSH, $urandom_range(0, 3));
		wait_drained();
		for (int i = 0; i < 6; i++)
			send_request(ldd_pkg::CMD_POP, $urandom);
	endtask

	task automatic test_random_traffic();
		logic [ldd_pkg::WORD_W-1:0] pool [8];
		int sent;
		int kind;
		int len;
		pool[0] = 32'h0;
		pool[1] = 32'hFFFF_FFFF;
		pool[2] = 32'h8000_0000;
		pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < 8; i++)
			pool[i] = $urandom;
		sent = 0;
		while (sent < 560) begin
			kind       = $urandom_range(0, 9);
			len        = $urandom_range(1, 18);
			tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
			rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
			for (int i = 0; i < len; i++) begin
				if (kind <= 4)
					send_request(ldd_pkg::CMD_PUSH,
							$urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : $urandom);
				else if (kind <= 7)
					send_request(ldd_pkg::CMD_POP, $urandom);
				else if (kind == 8)
					send_request(ldd_pkg::CMD_CLEAR, $urandom);
				else
					send_request(ldd_pkg::CMD_W'($urandom_range(0, 3)), $urandom);
			end
			sent += len;
		end
	endtask

	// result side: random per-result stall, plus the long hold on request
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_len > 0) begin
				stall       = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				stall = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid && rx_hold_len == 0) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_status_q.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
			end else begin
				want_status = expected_status_q.pop_front();
				got_status  = m_axis_tdata[40:0];
				if (got_status.top_value !== want_status.top_value)
					report_mismatch("top_value", got_status.top_value, want_status.top_value);
				if (got_status.entry_count !== want_status.entry_count)
					report_mismatch("entry_count", 32'(got_status.entry_count),
							32'(want_status.entry_count));
				if (got_status.is_empty !== want_status.is_empty)
					report_mismatch("is_empty", 32'(got_status.is_empty),
							32'(want_status.is_empty));
				if (got_status.is_full !== want_status.is_full)
					report_mismatch("is_full", 32'(got_status.is_full),
							32'(want_status.is_full));
				if (got_status.has_duplicate !== want_status.has_duplicate)
					report_mismatch("has_duplicate", 32'(got_status.has_duplicate),
							32'(want_status.has_duplicate));
				if (got_status.push_rejected !== want_status.push_rejected)
					report_mismatch("push_rejected", 32'(got_status.push_rejected),
							32'(want_status.push_rejected));
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ldd_pkg::CMD_PUSH;
		fail_count    = 0;
		tx_gap_max    = 0;
		rx_gap_max    = 0;
		rx_hold_len   = 0;
		idle_cycles   = 0;
		shadow_count  = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_fill_and_overflow();
		test_output_backpressure();
		test_drain_between_bursts();
		test_random_traffic();

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/ldd_pkg.sv
hdl/ldd_cell.sv
hdl/lifo_stack_duplicate_detect_core.sv
hdl/ldd_checker.sv
bench/tb_lifo_stack_duplicate_detect_core.sv
